// ===== hdl/dual_wheel_speed_pi_controller_unit_defines.svh =====
// Assertion macros shared by the controller RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef DUAL_WHEEL_SPEED_PI_CONTROLLER_UNIT_DEFINES_SVH
`define DUAL_WHEEL_SPEED_PI_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define DWSPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A condition that must be followed in the next cycle by a consequence.
`define DWSPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DWSPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define DWSPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/dwspc_pkg.sv =====
`timescale 1ns / 1ps

package dwspc_pkg;

  // Fixed-point formats: errors and integrals, then gains.
  localparam int ErrFracBits  = 8;
  localparam int GainFracBits = 24;
  localparam int OutShift     = ErrFracBits + GainFracBits;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegPropGain     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIntegralLimit = 2'd2;

  localparam int LimitW = 22;

  // Register reset values: kp = -1.0 and ki = -1/200, truncated.
  localparam logic signed [31:0] PropGainRst  = 32'(-(64'sd1 <<< GainFracBits));
  localparam logic signed [31:0] IntegGainRst =
    32'(-((64'sd1 <<< GainFracBits) / 64'sd200));
  localparam logic [LimitW-1:0]  LimitRst     = 22'd1000000;

  // Datapath widths. The filter numerator stays below 2^37 for any format in range.
  localparam int AccW   = 40;
  localparam int BndW   = LimitW + 16;
  localparam int SumW   = 65;
  localparam int SatInW = 66;

  // Division by ten by shift and add: a start step at 0.75*n, four steps that
  // refine it towards 0.8*n, and a last step that divides by eight and forms the
  // remainder modulo 32, which then lies below twenty.
  localparam int DivSteps = 6;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int RemW     = 5;
  localparam logic [RemW-1:0] FiltDivisor = 5'd10;

  // Largest integral bound, the signed 32-bit maximum.
  localparam logic [30:0] BoundMax = '1;

  // Bias that turns the arithmetic shift into truncation toward zero.
  localparam logic [SumW-1:0] RndMask = (SumW'(1) << OutShift) - SumW'(1);

  localparam logic signed [SatInW-1:0] SatMax = SatInW'(32'sh7FFF_FFFF);
  localparam logic signed [SatInW-1:0] SatMin = SatInW'(32'sh8000_0000);

  // Micro-program step addresses.
  localparam int PcW = 4;
  localparam logic [PcW-1:0] StepIdle  = 4'd0;
  localparam logic [PcW-1:0] StepErr   = 4'd1;
  localparam logic [PcW-1:0] StepMix   = 4'd2;
  localparam logic [PcW-1:0] StepDiv   = 4'd3;
  localparam logic [PcW-1:0] StepFilt  = 4'd4;
  localparam logic [PcW-1:0] StepInteg = 4'd5;
  localparam logic [PcW-1:0] StepMulP  = 4'd6;
  localparam logic [PcW-1:0] StepMulI  = 4'd7;
  localparam logic [PcW-1:0] StepAdd   = 4'd8;
  localparam logic [PcW-1:0] StepRnd   = 4'd9;
  localparam logic [PcW-1:0] StepDone  = 4'd10;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ERR,
    OP_MIX,
    OP_DIV,
    OP_FILT,
    OP_INTEG,
    OP_MULP,
    OP_MULI,
    OP_ADD,
    OP_RND,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT,
    C_DIV_MORE,
    C_WHEEL0,
    C_OUT_BUSY
  } cond_e;

  // One control word: datapath action, stay condition, jump condition and target.
  typedef struct packed {
    op_e             op;
    cond_e           hold;
    cond_e           jump;
    logic [PcW-1:0]  target;
  } ucode_t;

  // Status flags that the sequencer branches on.
  typedef struct packed {
    logic no_beat;
    logic div_more;
    logic wheel0;
    logic out_busy;
  } cond_flags_t;

  // The control store. Each wheel runs steps Err to Rnd; Done hands the beat out.
  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      StepIdle:  w = '{op: OP_IDLE,  hold: C_NO_BEAT,  jump: C_NEVER,    target: StepIdle};
      StepErr:   w = '{op: OP_ERR,   hold: C_NEVER,    jump: C_NEVER,    target: StepIdle};
      StepMix:   w = '{op: OP_MIX,   hold: C_NEVER,    jump: C_NEVER,    target: StepIdle};
      StepDiv:   w = '{op: OP_DIV,   hold: C_NEVER,    jump: C_DIV_MORE, target: StepDiv};
      StepFilt:  w = '{op: OP_FILT,  hold: C_NEVER,    jump: C_NEVER,    target: StepIdle};
      StepInteg: w = '{op: OP_INTEG, hold: C_NEVER,    jump: C_NEVER,    target: StepIdle};
      StepMulP:  w = '{op: OP_MULP,  hold: C_NEVER,    jump: C_NEVER,    target: StepIdle};
      StepMulI:  w = '{op: OP_MULI,  hold: C_NEVER,    jump: C_NEVER,    target: StepIdle};
      StepAdd:   w = '{op: OP_ADD,   hold: C_NEVER,    jump: C_NEVER,    target: StepIdle};
      StepRnd:   w = '{op: OP_RND,   hold: C_NEVER,    jump: C_WHEEL0,   target: StepErr};
      StepDone:  w = '{op: OP_DONE,  hold: C_OUT_BUSY, jump: C_ALWAYS,   target: StepIdle};
      default:   w = '{op: OP_IDLE,  hold: C_NEVER,    jump: C_ALWAYS,   target: StepIdle};
    endcase
    return w;
  endfunction

  function automatic logic cond_eval(cond_e c, cond_flags_t f);
    logic r;
    unique case (c)
      C_NEVER:    r = 1'b0;
      C_ALWAYS:   r = 1'b1;
      C_NO_BEAT:  r = f.no_beat;
      C_DIV_MORE: r = f.div_more;
      C_WHEEL0:   r = f.wheel0;
      C_OUT_BUSY: r = f.out_busy;
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  // Saturation to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(logic signed [SatInW-1:0] v);
    logic signed [31:0] r;
    if (v > SatMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SatMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/dual_wheel_speed_pi_controller_unit.sv =====
`timescale 1ns / 1ps

// Speed PI controller for two wheels. Each input beat carries a goal and an encoder
// speed per wheel (the right reading is negated); the result beat carries the two
// drive values. Per wheel the error goal - 5.25*speed is low-pass filtered
// (0.7 new, 0.3 old), accumulated into an integral (left saturates at the limit,
// right drops to zero when it leaves it) and driven as kp*filtered + ki*integral,
// truncated toward zero and saturated to 32 bits. A small micro-program steers one
// shared datapath: each wheel runs the steps Err to Rnd, with the shift-and-add
// division by ten of the filter and the single shared 32x32 multiplier. A new item
// is accepted only in Idle, after both wheels are done. A finished result waits in
// the output register while the next item is already being worked on; the sequencer
// only stalls in its last step if that register is still full.
// Configuration writes are expected while the block is idle.

`include "dual_wheel_speed_pi_controller_unit_defines.svh"

module dual_wheel_speed_pi_controller_unit
  import dwspc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [15:0]       goal_left_i,
  input  logic signed [15:0]       goal_right_i,
  input  logic signed [15:0]       measured_left_i,
  input  logic signed [15:0]       measured_right_i,
  // Result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [31:0]       drive_left_o,
  output logic signed [31:0]       drive_right_o,
  // Configuration write port
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [31:0]              cfg_data_i
);

  // Sequencer
  ucode_t             cw;
  cond_flags_t        flags;
  logic [PcW-1:0]     pc_q, pc_d;
  logic               wheel_q;
  logic               out_valid_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               in_accept;
  logic               out_load;

  // Configuration
  logic signed [31:0] prop_gain_q;
  logic signed [31:0] integ_gain_q;
  logic [LimitW-1:0]  limit_q;

  // Controller state per wheel
  logic signed [31:0] filt_q  [2];
  logic signed [31:0] integ_q [2];

  // Captured beat and working registers
  logic signed [15:0] goal_l_q, goal_r_q, meas_l_q, meas_r_q;
  logic signed [AccW-1:0] acc_q;
  logic [AccW-1:0]    num_q;
  logic [AccW-1:0]    quo_q;
  logic [RemW-1:0]    rem_q;
  logic               neg_q;
  logic signed [63:0] prod_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [31:0] res_q [2];
  logic signed [31:0] drive_l_q, drive_r_q;

  // Datapath nets
  logic signed [15:0]     goal_sel;
  logic signed [16:0]     speed_sel;
  logic signed [AccW-1:0] speed_x, goal_x, speed21, err_val;
  logic signed [AccW-1:0] filt_x, mix_val;
  logic [AccW-1:0]        mix_mag;
  logic [5:0]             div_sh;
  logic [AccW-1:0]        quo_sh;
  logic [AccW-1:0]        div_quo;
  logic [RemW-1:0]        div_rem;
  logic [AccW-1:0]        quot_mag;
  logic signed [AccW:0]   quot_s;
  logic signed [31:0]     filt_new;
  logic [BndW-1:0]        lim_sh;
  logic [30:0]            bound;
  logic signed [32:0]     bnd_pos, bnd_neg;
  logic signed [32:0]     integ_sum;
  logic signed [31:0]     integ_new;
  logic signed [31:0]     mul_a, mul_b;
  logic signed [63:0]     mul_p;
  logic signed [SumW-1:0] rnd_bias, rnd_q;
  logic signed [31:0]     rnd_sat;
  logic signed [32:0]     integ_l_ext;

  // Control word fetch and branch flags
  assign cw             = ucode_rom(pc_q);
  assign flags.no_beat  = !in_valid_i;
  assign flags.div_more = (div_cnt_q != DivCntW'(DivSteps - 1));
  assign flags.wheel0   = !wheel_q;
  assign flags.out_busy = out_valid_q && !out_ready_i;

  assign in_ready_o = (cw.op == OP_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_load   = (cw.op == OP_DONE) && !flags.out_busy;

  // Next step: stay, jump or fall through.
  always_comb begin
    if (cond_eval(cw.hold, flags)) begin
      pc_d = pc_q;
    end else if (cond_eval(cw.jump, flags)) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + PcW'(1);
    end
  end

  // Error: goal*2^F - 21*speed*2^(F-2), with the right reading negated.
  always_comb begin
    goal_sel  = wheel_q ? goal_r_q : goal_l_q;
    speed_sel = wheel_q ? -(17'(meas_r_q)) : 17'(meas_l_q);
    speed_x   = AccW'(speed_sel);
    goal_x    = AccW'(goal_sel);
    speed21   = (speed_x <<< 4) + (speed_x <<< 2) + speed_x;
    err_val   = (goal_x <<< ErrFracBits) - (speed21 <<< (ErrFracBits - 2));
  end

  // Filter numerator 7*error + 3*previous, split into sign and magnitude.
  always_comb begin
    filt_x  = AccW'(filt_q[wheel_q]);
    mix_val = (acc_q <<< 3) - acc_q + (filt_x <<< 1) + filt_x;
    mix_mag = mix_val[AccW-1] ? AccW'(-mix_val) : AccW'(mix_val);
  end

  // Division by ten, one addition a cycle. The estimate starts at 0.75*n and each
  // refinement multiplies it by 1 + 2^-k (k = 4, 8, 16, 32), which approaches 0.8*n
  // from below; the last step divides by eight. The quotient is then at most one
  // short, and the remainder, taken modulo 32, is exact.
  always_comb begin
    div_sh  = 6'd2 << div_cnt_q;
    quo_sh  = quo_q >> 3;
    div_quo = quo_q + (quo_q >> div_sh);
    div_rem = rem_q;
    if (div_cnt_q == '0) begin
      div_quo = (num_q >> 1) + (num_q >> 2);
    end else if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
      div_quo = quo_sh;
      div_rem = num_q[RemW-1:0]
              - ((quo_sh[RemW-1:0] << 3) + (quo_sh[RemW-1:0] << 1));
    end
  end

  // Quotient corrected by one when the remainder reaches ten, then the sign
  // restored, so it truncates toward zero.
  assign quot_mag = quo_q + AccW'(rem_q >= FiltDivisor);
  assign quot_s   = neg_q ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
  assign filt_new = sat32(SatInW'(quot_s));

  // Integral bound in state units, capped at the 32-bit maximum.
  always_comb begin
    lim_sh  = BndW'(limit_q) << ErrFracBits;
    bound   = (lim_sh > BndW'(BoundMax)) ? BoundMax : lim_sh[30:0];
    bnd_pos = $signed({2'b00, bound});
    bnd_neg = -bnd_pos;
  end

  // Integral update: the left wheel clamps, the right wheel restarts from zero.
  always_comb begin
    integ_sum = 33'(integ_q[wheel_q]) + 33'(filt_q[wheel_q]);
    integ_new = integ_sum[31:0];
    if (!wheel_q) begin
      if (integ_sum > bnd_pos) begin
        integ_new = bnd_pos[31:0];
      end else if (integ_sum < bnd_neg) begin
        integ_new = bnd_neg[31:0];
      end
    end else if ((integ_sum > bnd_pos) || (integ_sum < bnd_neg)) begin
      integ_new = '0;
    end
  end

  // Shared multiplier: kp*filtered first, then ki*integral.
  always_comb begin
    mul_a = (cw.op == OP_MULP) ? filt_q[wheel_q] : integ_q[wheel_q];
    mul_b = (cw.op == OP_MULP) ? prop_gain_q : integ_gain_q;
    mul_p = mul_a * mul_b;
  end

  // Drop the fraction bits toward zero and saturate.
  always_comb begin
    rnd_bias = sum_q[SumW-1] ? $signed(RndMask) : '0;
    rnd_q    = (sum_q + rnd_bias) >>> OutShift;
    rnd_sat  = sat32(SatInW'(rnd_q));
  end

  // Control state, configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= StepIdle;
      wheel_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
      prop_gain_q  <= PropGainRst;
      integ_gain_q <= IntegGainRst;
      limit_q      <= LimitRst;
      filt_q[0]    <= '0;
      filt_q[1]    <= '0;
      integ_q[0]   <= '0;
      integ_q[1]   <= '0;
    end else begin
      pc_q <= pc_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegPropGain:      prop_gain_q  <= cfg_data_i;
          RegIntegGain:     integ_gain_q <= cfg_data_i;
          RegIntegralLimit: limit_q      <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end

      if (cw.op == OP_MIX) begin
        div_cnt_q <= '0;
      end else if (cw.op == OP_DIV) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end

      if (cw.op == OP_FILT) begin
        filt_q[wheel_q] <= filt_new;
      end
      if (cw.op == OP_INTEG) begin
        integ_q[wheel_q] <= integ_new;
      end
      if (cw.op == OP_RND) begin
        wheel_q <= !wheel_q;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the datapath
  always_ff @(posedge clk_i) begin
    unique case (cw.op)
      OP_IDLE: begin
        if (in_accept) begin
          goal_l_q <= goal_left_i;
          goal_r_q <= goal_right_i;
          meas_l_q <= measured_left_i;
          meas_r_q <= measured_right_i;
        end
      end
      OP_ERR: acc_q <= err_val;
      OP_MIX: begin
        num_q <= mix_mag;
        neg_q <= mix_val[AccW-1];
      end
      OP_DIV: begin
        quo_q <= div_quo;
        rem_q <= div_rem;
      end
      OP_MULP: prod_q <= mul_p;
      OP_MULI: begin
        sum_q  <= SumW'(prod_q);
        prod_q <= mul_p;
      end
      OP_ADD: sum_q <= sum_q + SumW'(prod_q);
      OP_RND: res_q[wheel_q] <= rnd_sat;
      OP_DONE: begin
        if (out_load) begin
          drive_l_q <= res_q[0];
          drive_r_q <= res_q[1];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign drive_left_o  = drive_l_q;
  assign drive_right_o = drive_r_q;

  // Checks
  assign integ_l_ext = 33'(integ_q[0]);

  `DWSPC_ASSERT(a_idle_left_wheel, clk_i, rst_ni, (cw.op == OP_IDLE) |-> !wheel_q, "sequencer idle with right wheel selected")
  `DWSPC_ASSERT(a_out_after_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cw.op == OP_DONE), "result raised outside the final step")
  `DWSPC_ASSERT_NEXT(a_div_exit, clk_i, rst_ni, (cw.op == OP_DIV) && !flags.div_more, cw.op == OP_FILT, "division did not finish after its last step")
  `DWSPC_ASSERT_NEXT(a_left_integ_bound, clk_i, rst_ni, (cw.op == OP_INTEG) && !wheel_q, (integ_l_ext <= $past(bnd_pos)) && (integ_l_ext >= $past(bnd_neg)), "left integral outside its bound")

endmodule
